### sv/umsp_pkg.sv
package umsp_pkg;

	// defaults for the top-level parameters
	localparam int COMMAND_STORE_SIZE_DEF = 32;
	localparam int STRING_MAX_DEF         = 30;

	// byte values
	localparam logic [7:0] HDR_BYTE   = 8'h77;
	localparam logic [7:0] EOX_BYTE   = 8'hF7;
	localparam logic [7:0] CMD_RESET  = 8'h0A;
	localparam logic [7:0] CMD_STRING = 8'h0B;
	localparam logic [7:0] CMD_IDS    = 8'h0C;

	// set-ids command length: command byte plus eight nibble bytes
	localparam int IDS_LEN = 9;

	// code index numbers
	localparam logic [3:0] CIN_CONT     = 4'd4;
	localparam logic [3:0] CIN_END_BASE = 4'd5;

	// result kinds
	localparam logic [2:0] KIND_PACKET = 3'd0;
	localparam logic [2:0] KIND_RESET  = 3'd1;
	localparam logic [2:0] KIND_IDS    = 3'd2;
	localparam logic [2:0] KIND_CHAR   = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;
	localparam logic [2:0] KIND_REJECT = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CLOSE,
		ST_RESET,
		ST_IDS,
		ST_REJECT,
		ST_SINIT,
		ST_RD,
		ST_CHAR,
		ST_SDONE,
		ST_WRAP,
		ST_ADD,
		ST_FULL
	} state_t;

	typedef enum logic [2:0] {
		OS_CLOSE,
		OS_FULL,
		OS_RESET,
		OS_IDS,
		OS_REJECT,
		OS_CHAR,
		OS_DONE
	} out_sel_t;

	typedef enum logic [1:0] {
		CC_NONE,
		CC_RESET,
		CC_STRING,
		CC_IDS
	} cmd_class_t;

	typedef struct packed {
		logic     capture;
		logic     load_out;
		out_sel_t out_sel;
		logic     out_last;
		logic     clr_hdr;
		logic     add;
		logic     rd_start;
		logic     rd_issue;
		logic     idx_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic       close_hit;
		logic       sx;
		logic       run_cmd;
		logic       has_res;
		cmd_class_t cmd_class;
		logic       str_ok;
		logic       str_empty;
		logic       ids_ok;
		logic       add_full;
		logic       chars_last;
		logic       out_free;
	} dp_status_t;

endpackage

### sv/umsp_ram.sv
module umsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/umsp_ctrl.sv
module umsp_ctrl import umsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				priority if (status.close_hit) state_d = ST_CLOSE;
				else if (status.sx)            state_d = ST_ADD;
				else                           state_d = ST_IDLE;
			end
			ST_CLOSE: begin
				if (status.out_free) begin
					if (status.run_cmd) begin
						unique case (status.cmd_class)
							CC_RESET:  state_d = ST_RESET;
							CC_IDS:    state_d = status.ids_ok ? ST_IDS : ST_WRAP;
							CC_STRING: begin
								priority if (!status.str_ok)  state_d = ST_REJECT;
								else if (status.str_empty)    state_d = ST_SDONE;
								else                          state_d = ST_SINIT;
							end
							default:   state_d = ST_WRAP;
						endcase
					end else begin
						state_d = ST_WRAP;
					end
				end
			end
			ST_RESET, ST_IDS, ST_REJECT, ST_SDONE: begin
				if (status.out_free) state_d = ST_WRAP;
			end
			ST_SINIT: state_d = ST_RD;
			ST_RD:    state_d = ST_CHAR;
			ST_CHAR: begin
				if (status.out_free) state_d = status.chars_last ? ST_SDONE : ST_RD;
			end
			ST_WRAP: state_d = status.sx ? ST_ADD : ST_IDLE;
			ST_ADD:  state_d = status.add_full ? ST_FULL : ST_IDLE;
			ST_FULL: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.out_sel = OS_CLOSE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_CLOSE: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_CLOSE;
				cmd.out_last = !status.has_res;
			end
			ST_RESET: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_RESET;
				cmd.out_last = 1'b1;
			end
			ST_IDS: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_IDS;
				cmd.out_last = 1'b1;
			end
			ST_REJECT: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_REJECT;
				cmd.out_last = 1'b1;
			end
			ST_SDONE: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_DONE;
				cmd.out_last = 1'b1;
			end
			ST_SINIT: cmd.rd_start = 1'b1;
			ST_RD:    cmd.rd_issue = 1'b1;
			ST_CHAR: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_CHAR;
				cmd.idx_inc  = status.out_free;
			end
			ST_WRAP: cmd.clr_hdr = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_FULL: begin
				cmd.load_out = status.out_free;
				cmd.out_sel  = OS_FULL;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### sv/umsp_dp.sv
module umsp_dp import umsp_pkg::*; #(
	parameter int COMMAND_STORE_SIZE = COMMAND_STORE_SIZE_DEF,
	parameter int STRING_MAX         = STRING_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        in_sysex,
	input  logic        sysex_error,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  cin,
	output logic [7:0]  byte_one,
	output logic [7:0]  byte_two,
	output logic [7:0]  byte_three,
	output logic [15:0] vendor_id,
	output logic [15:0] product_id,
	output logic [6:0]  string_char,
	output logic [4:0]  string_pos,
	output logic        last
);

	localparam int DEPTH  = COMMAND_STORE_SIZE - 1;
	localparam int LEN_W  = $clog2(COMMAND_STORE_SIZE);
	localparam int ADDR_W = $clog2(DEPTH);

	// captured word
	logic [7:0] byte_q;
	logic       sx_q;
	logic       err_q;

	// packet being filled
	logic [1:0] pend_cnt_q;
	logic [7:0] pend_q [3];

	// header match and command capture
	logic [1:0]       hdr_idx_q;
	logic             hdr_found_q;
	logic [LEN_W-1:0] cmd_len_q;
	logic [7:0]       cmd_q;
	logic             bad_q;
	logic [15:0]      vid_q;
	logic [15:0]      pid_q;
	logic [LEN_W-1:0] idx_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [3:0]  cin_q;
	logic [7:0]  b1_q, b2_q, b3_q;
	logic [15:0] vid_out_q, pid_out_q;
	logic [6:0]  char_q;
	logic [4:0]  pos_q;
	logic        last_q;

	logic             out_free;
	logic [1:0]       slot;
	logic [LEN_W-1:0] pos_new;
	logic [LEN_W-1:0] pos_m2;
	logic [15:0]      term;
	logic             store_ok;
	logic             ram_we;
	logic [7:0]       ram_rdata;
	logic [5:0]       len_m1;

	assign out_free = !out_valid_q || out_ready;

	// free slot of the pending packet (count never exceeds two outside a full emit)
	assign slot = (pend_cnt_q > 2'd2) ? 2'd2 : pend_cnt_q;

	// position of the byte that would be stored next, and its nibble weight
	assign pos_new  = cmd_len_q + LEN_W'(1);
	assign pos_m2   = pos_new - LEN_W'(2);
	assign term     = 16'(byte_q) << {~pos_m2[1:0], 2'b00};
	assign store_ok = hdr_found_q && (cmd_len_q < LEN_W'(DEPTH));
	assign ram_we   = cmd.add && store_ok;
	assign len_m1   = 6'(cmd_len_q) - 6'd1;

	umsp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_len_q[ADDR_W-1:0]),
		.wdata (byte_q),
		.re    (cmd.rd_issue),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= data_byte;
			sx_q   <= in_sysex;
			err_q  <= sysex_error;
		end
	end

	// packet assembly and header tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= '0;
			pend_q      <= '{default: '0};
			hdr_idx_q   <= '0;
			hdr_found_q <= 1'b0;
			cmd_len_q   <= '0;
		end else begin
			if (cmd.load_out && (cmd.out_sel == OS_CLOSE || cmd.out_sel == OS_FULL)) begin
				pend_cnt_q <= '0;
				pend_q     <= '{default: '0};
			end
			if (cmd.clr_hdr) begin
				hdr_found_q <= 1'b0;
				hdr_idx_q   <= '0;
				cmd_len_q   <= '0;
			end
			if (cmd.add) begin
				pend_q[slot] <= byte_q;
				pend_cnt_q   <= slot + 2'd1;
				if (hdr_found_q) begin
					if (store_ok) cmd_len_q <= pos_new;
				end else if (byte_q == HDR_BYTE) begin
					if (hdr_idx_q == 2'd2) begin
						hdr_idx_q   <= 2'd3;
						hdr_found_q <= 1'b1;
						cmd_len_q   <= '0;
					end else begin
						hdr_idx_q <= hdr_idx_q + 2'd1;
					end
				end else begin
					hdr_idx_q <= '0;
				end
			end
		end
	end

	// running decode of the stored command: command byte, bad-char flag, id sums
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			if (!hdr_found_q && byte_q == HDR_BYTE && hdr_idx_q == 2'd2) begin
				bad_q <= 1'b0;
				vid_q <= '0;
				pid_q <= '0;
			end else if (store_ok) begin
				if (pos_new == LEN_W'(1)) begin
					cmd_q <= byte_q;
				end else if (byte_q[7]) begin
					bad_q <= 1'b1;
				end
				if (pos_new >= LEN_W'(2) && pos_new <= LEN_W'(5)) vid_q <= vid_q + term;
				if (pos_new >= LEN_W'(6) && pos_new <= LEN_W'(9)) pid_q <= pid_q + term;
			end
		end
		if (cmd.rd_start) begin
			idx_q <= LEN_W'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + LEN_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q    <= KIND_PACKET;
			cin_q     <= '0;
			b1_q      <= '0;
			b2_q      <= '0;
			b3_q      <= '0;
			vid_out_q <= '0;
			pid_out_q <= '0;
			char_q    <= '0;
			pos_q     <= '0;
			last_q    <= cmd.out_last;
			unique case (cmd.out_sel)
				OS_CLOSE: begin
					cin_q <= CIN_END_BASE + 4'(slot);
					b1_q  <= (slot == 2'd0) ? EOX_BYTE : pend_q[0];
					b2_q  <= (slot == 2'd1) ? EOX_BYTE : pend_q[1];
					b3_q  <= (slot == 2'd2) ? EOX_BYTE : pend_q[2];
				end
				OS_FULL: begin
					cin_q <= CIN_CONT;
					b1_q  <= pend_q[0];
					b2_q  <= pend_q[1];
					b3_q  <= pend_q[2];
				end
				OS_RESET:  kind_q <= KIND_RESET;
				OS_IDS: begin
					kind_q    <= KIND_IDS;
					vid_out_q <= vid_q;
					pid_out_q <= pid_q;
				end
				OS_REJECT: kind_q <= KIND_REJECT;
				OS_CHAR: begin
					kind_q <= KIND_CHAR;
					char_q <= ram_rdata[6:0];
					pos_q  <= 5'(idx_q - LEN_W'(1));
				end
				OS_DONE: begin
					kind_q <= KIND_DONE;
					pos_q  <= len_m1[4:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status.close_hit  = (byte_q == EOX_BYTE) || err_q;
		status.sx         = sx_q;
		status.run_cmd    = hdr_found_q && (cmd_len_q != '0);
		unique case (cmd_q)
			CMD_RESET:  status.cmd_class = CC_RESET;
			CMD_STRING: status.cmd_class = CC_STRING;
			CMD_IDS:    status.cmd_class = CC_IDS;
			default:    status.cmd_class = CC_NONE;
		endcase
		status.ids_ok     = (cmd_len_q == LEN_W'(IDS_LEN));
		status.str_ok     = (len_m1 <= 6'(STRING_MAX)) && !bad_q;
		status.str_empty  = (cmd_len_q == LEN_W'(1));
		status.has_res    = status.run_cmd && (status.cmd_class == CC_RESET ||
		                    status.cmd_class == CC_STRING ||
		                    (status.cmd_class == CC_IDS && status.ids_ok));
		status.add_full   = (slot == 2'd2);
		status.chars_last = (idx_q == len_m1[LEN_W-1:0]);
		status.out_free   = out_free;
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign cin         = cin_q;
	assign byte_one    = b1_q;
	assign byte_two    = b2_q;
	assign byte_three  = b3_q;
	assign vendor_id   = vid_out_q;
	assign product_id  = pid_out_q;
	assign string_char = char_q;
	assign string_pos  = pos_q;
	assign last        = last_q;

endmodule

### sv/usb_midi_sysex_packetizer.sv
// USB-MIDI sysex packetizer.
// Input channel (in_valid/in_ready): one word per parser byte, carrying
// data_byte, in_sysex and sysex_error. Output channel (out_valid/out_ready):
// one word per result, either a 4-byte event packet (kind 0, cin 4..7) or a
// command result (reset, set ids, string char/done/rejected). last marks the
// final result caused by an input word; a word may cause no result.
// Words are taken one at a time: in_ready is high only while the controller
// is idle. A plain byte is added to the pending packet, and a byte that
// fills it also emits it. A closing byte emits the closing packet, then any
// reset, set ids, rejected or done result, and is added to a new packet if
// it also starts a new sysex; a product string adds a setup step and, per
// character, a store read followed by a result load.
// Results go through a single output register: the next result loads in
// the cycle the previous one is taken, so an unstalled receiver sees one
// result per cycle at most; a stalled receiver just holds the controller in
// its emit state, nothing is dropped.
// Reset (arst_n low) clears the pending packet, header match and command
// length; the command store itself is not cleared, only entries written
// since the last header are ever read.
module usb_midi_sysex_packetizer import umsp_pkg::*; #(
	parameter int COMMAND_STORE_SIZE = COMMAND_STORE_SIZE_DEF,
	parameter int STRING_MAX         = STRING_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        in_sysex,
	input  logic        sysex_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  cin,
	output logic [7:0]  byte_one,
	output logic [7:0]  byte_two,
	output logic [7:0]  byte_three,
	output logic [15:0] vendor_id,
	output logic [15:0] product_id,
	output logic [6:0]  string_char,
	output logic [4:0]  string_pos,
	output logic        last
);

	// controller drives the datapath with one command word per cycle
	dp_cmd_t    cmd;
	dp_status_t status;

	umsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// packet assembly, header/command capture, store and result register
	umsp_dp #(
		.COMMAND_STORE_SIZE (COMMAND_STORE_SIZE),
		.STRING_MAX         (STRING_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.in_sysex    (in_sysex),
		.sysex_error (sysex_error),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.cin         (cin),
		.byte_one    (byte_one),
		.byte_two    (byte_two),
		.byte_three  (byte_three),
		.vendor_id   (vendor_id),
		.product_id  (product_id),
		.string_char (string_char),
		.string_pos  (string_pos),
		.last        (last)
	);

endmodule
